[rtl/sld_pkg.sv]
package sld_pkg;

  localparam int unsigned AddrW = 4;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] RegSyncFirst  = 2'd0;
  localparam logic [1:0] RegSyncSecond = 2'd1;
  localparam logic [1:0] RegMaxPayload = 2'd2;
  localparam logic [1:0] RegMaxLog     = 2'd3;

  localparam logic [7:0]  SyncFirstRst  = 8'd148;
  localparam logic [7:0]  SyncSecondRst = 8'd195;
  localparam logic [15:0] MaxPayloadRst = 16'd512;
  localparam logic [15:0] MaxLogRst     = 16'd511;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_LOG_CHAR = 3'd1,
    KIND_LINE_END = 3'd2,
    KIND_EMPTY    = 3'd3,
    KIND_LEN_ERR  = 3'd4
  } sld_kind_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload_length;
    logic [15:0] max_log_chars;
  } sld_cfg_t;

endpackage

[rtl/sync_length_frame_deframer_core.sv]
// channel | direction | handshake               | payload
// rx      | in        | rx_valid_i / rx_ready_o | rx_byte_i
// out     | out       | out_valid_o/out_ready_i | kind_o, data_o, frame_end_o, frame_length_o
// cfg     | in        | APB, pready tied high   | paddr, pwdata, prdata
//
// One byte per cycle: each accepted byte updates the phase and counters in the
// same cycle and loads at most one result into the output register.
// A byte is taken whenever the output register is empty or drained this cycle.
// Reset puts the deframer in the first-sync hunt with the register defaults.
// A stalled output beat holds its value and stops input until taken.
module sync_length_frame_deframer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rx_valid_i,
  output logic                      rx_ready_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                kind_o,
  output logic [7:0]                data_o,
  output logic                      frame_end_o,
  output logic [15:0]               frame_length_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sld_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import sld_pkg::*;

  localparam logic [2:0] PhHunt1   = 3'd0;
  localparam logic [2:0] PhHunt2   = 3'd1;
  localparam logic [2:0] PhLenHi   = 3'd2;
  localparam logic [2:0] PhLenLo   = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;

  sld_cfg_t cfg;

  sld_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] frame_len_q, frame_len_d;
  logic [15:0] remaining_q, remaining_d;
  logic [15:0] log_count_q, log_count_d;

  logic        out_valid_q;
  sld_kind_e   kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic        end_q, end_d;
  logic [15:0] flen_q, flen_d;
  logic        emit;
  logic        in_fire;
  logic [15:0] len_rx;

  assign rx_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = rx_valid_i && rx_ready_o;
  assign len_rx     = {len_hi_q, rx_byte_i};

  always_comb begin
    phase_d     = phase_q;
    len_hi_d    = len_hi_q;
    frame_len_d = frame_len_q;
    remaining_d = remaining_q;
    log_count_d = log_count_q;
    emit        = 1'b0;
    kind_d      = KIND_PAYLOAD;
    data_d      = 8'd0;
    end_d       = 1'b0;
    flen_d      = 16'd0;
    case (phase_q)
      PhHunt2: begin
        phase_d = (rx_byte_i == cfg.sync_second) ? PhLenHi : PhHunt1;
      end
      PhLenHi: begin
        len_hi_d = rx_byte_i;
        phase_d  = PhLenLo;
      end
      PhLenLo: begin
        frame_len_d = len_rx;
        if (len_rx > cfg.max_payload_length) begin
          phase_d = PhHunt1;
          emit    = 1'b1;
          kind_d  = KIND_LEN_ERR;
          flen_d  = len_rx;
        end else if (len_rx == 16'd0) begin
          phase_d = PhHunt1;
          emit    = 1'b1;
          kind_d  = KIND_EMPTY;
          end_d   = 1'b1;
        end else begin
          remaining_d = len_rx;
          phase_d     = PhPayload;
        end
      end
      PhPayload: begin
        emit   = 1'b1;
        kind_d = KIND_PAYLOAD;
        data_d = rx_byte_i;
        flen_d = frame_len_q;
        if (remaining_q <= 16'd1) begin
          remaining_d = 16'd0;
          end_d       = 1'b1;
          phase_d     = PhHunt1;
        end else begin
          remaining_d = remaining_q - 16'd1;
        end
      end
      default: begin
        // first-sync hunt; stray phase codes land here too
        if (rx_byte_i == cfg.sync_first) begin
          phase_d = PhHunt2;
        end else begin
          phase_d = PhHunt1;
          if (rx_byte_i == CharLf) begin
            log_count_d = 16'd0;
            emit        = 1'b1;
            kind_d      = KIND_LINE_END;
          end else if (rx_byte_i != CharCr && log_count_q < cfg.max_log_chars) begin
            log_count_d = log_count_q + 16'd1;
            emit        = 1'b1;
            kind_d      = KIND_LOG_CHAR;
            data_d      = rx_byte_i;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt1;
      len_hi_q    <= 8'd0;
      frame_len_q <= 16'd0;
      remaining_q <= 16'd0;
      log_count_q <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        len_hi_q    <= len_hi_d;
        frame_len_q <= frame_len_d;
        remaining_q <= remaining_d;
        log_count_q <= log_count_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      kind_q <= kind_d;
      data_q <= data_d;
      end_q  <= end_d;
      flen_q <= flen_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign data_o         = data_q;
  assign frame_end_o    = end_q;
  assign frame_length_o = flen_q;

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !rx_ready_o)
    else $error("input taken while output beat stalled");

  a_payload_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PhPayload) |=> (out_valid_o && kind_o == KIND_PAYLOAD))
    else $error("payload byte produced no payload beat");

  a_end_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> (kind_o == KIND_PAYLOAD || kind_o == KIND_EMPTY))
    else $error("frame end on non-frame beat");

  a_remaining_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (remaining_q != 16'd0))
    else $error("payload phase with nothing remaining");

endmodule

[rtl/sld_regs.sv]
module sld_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sld_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output sld_pkg::sld_cfg_t         cfg_o
);
  import sld_pkg::*;

  sld_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first         <= SyncFirstRst;
      cfg_q.sync_second        <= SyncSecondRst;
      cfg_q.max_payload_length <= MaxPayloadRst;
      cfg_q.max_log_chars      <= MaxLogRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegSyncFirst:  cfg_q.sync_first         <= pwdata[7:0];
        RegSyncSecond: cfg_q.sync_second        <= pwdata[7:0];
        RegMaxPayload: cfg_q.max_payload_length <= pwdata[15:0];
        RegMaxLog:     cfg_q.max_log_chars      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegSyncFirst:  prdata = {24'd0, cfg_q.sync_first};
      RegSyncSecond: prdata = {24'd0, cfg_q.sync_second};
      RegMaxPayload: prdata = {16'd0, cfg_q.max_payload_length};
      RegMaxLog:     prdata = {16'd0, cfg_q.max_log_chars};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

[tb/sync_length_frame_deframer_core_tb.sv]
module sync_length_frame_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sld_pkg::*;

  localparam int unsigned NumSettings = 6;
  localparam int unsigned DirectedBytes = 25;
  localparam int unsigned BytesPerSetting = 245;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StallLimit = 2000;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4
  } rx_phase_e;

  typedef struct packed {
    sld_kind_e   kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] flen;
  } deframe_beat_t;

  // Tracks the deframer state, predicts the beat for each received byte and
  // checks output beats in order.
  class deframe_checker;
    sld_cfg_t      cfg;
    rx_phase_e     phase;
    logic [7:0]    len_hi;
    logic [15:0]   frame_len;
    logic [15:0]   remaining;
    logic [15:0]   log_count;
    deframe_beat_t pending[$];
    int unsigned   errors;
    int unsigned   kind_seen[5];

    function new();
      cfg = '{SyncFirstRst, SyncSecondRst, MaxPayloadRst, MaxLogRst};
      phase = PH_SYNC1;
      len_hi = '0;
      frame_len = '0;
      remaining = '0;
      log_count = '0;
      errors = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegSyncFirst:  cfg.sync_first = value[7:0];
        RegSyncSecond: cfg.sync_second = value[7:0];
        RegMaxPayload: cfg.max_payload_length = value[15:0];
        RegMaxLog:     cfg.max_log_chars = value[15:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      deframe_beat_t r;
      bit            emit;
      r = '{KIND_PAYLOAD, 8'h00, 1'b0, 16'h0000};
      emit = 1'b0;
      case (phase)
        PH_SYNC2: phase = (b == cfg.sync_second) ? PH_LEN_HI : PH_SYNC1;
        PH_LEN_HI: begin
          len_hi = b;
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len = {len_hi, b};
          if (frame_len > cfg.max_payload_length) begin
            phase = PH_SYNC1;
            r.kind = KIND_LEN_ERR;
            r.flen = frame_len;
            emit = 1'b1;
          end else if (frame_len == 16'h0000) begin
            phase = PH_SYNC1;
            r.kind = KIND_EMPTY;
            r.last = 1'b1;
            emit = 1'b1;
          end else begin
            remaining = frame_len;
            phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          r.kind = KIND_PAYLOAD;
          r.data = b;
          r.flen = frame_len;
          emit = 1'b1;
          if (remaining <= 16'd1) begin
            remaining = '0;
            r.last = 1'b1;
            phase = PH_SYNC1;
          end else begin
            remaining = remaining - 16'd1;
          end
        end
        default: begin
          if (b == cfg.sync_first) begin
            phase = PH_SYNC2;
          end else begin
            phase = PH_SYNC1;
            if (b == CharLf) begin
              log_count = '0;
              r.kind = KIND_LINE_END;
              emit = 1'b1;
            end else if (b != CharCr && log_count < cfg.max_log_chars) begin
              log_count = log_count + 16'd1;
              r.kind = KIND_LOG_CHAR;
              r.data = b;
              emit = 1'b1;
            end
          end
        end
      endcase
      if (emit) pending.push_back(r);
    endfunction

    function void check_beat(deframe_beat_t got);
      deframe_beat_t exp;
      if (pending.size() == 0) begin
        $error("unexpected beat: kind %0d data %0h frame_end %0b frame_length %0d",
               got.kind, got.data, got.last, got.flen);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (exp.kind <= KIND_LEN_ERR) kind_seen[exp.kind]++;
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind);
        errors++;
      end
      if (got.data !== exp.data) begin
        $error("data: expected %0h, got %0h", exp.data, got.data);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("frame_end: expected %0b, got %0b", exp.last, got.last);
        errors++;
      end
      if (got.flen !== exp.flen) begin
        $error("frame_length: expected %0d, got %0d", exp.flen, got.flen);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              rx_valid = 1'b0;
  logic              rx_ready;
  logic [7:0]        rx_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        kind;
  logic [7:0]        data;
  logic              frame_end;
  logic [15:0]       frame_length;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  deframe_checker board = new();
  int unsigned    rx_count = 0;
  int unsigned    quiet_cycles = 0;
  bit             rx_gaps = 1'b1;
  bit             out_gaps = 1'b1;
  bit             hold_req = 1'b0;

  sync_length_frame_deframer_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .rx_valid_i     (rx_valid),
    .rx_ready_o     (rx_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .data_o         (data),
    .frame_end_o    (frame_end),
    .frame_length_o (frame_length),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // results are checked before the byte of the same edge is noted: a byte's
  // beat can only show up on a later edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_beat('{sld_kind_e'(kind), data, frame_end, frame_length});
      if (rx_valid && rx_ready) board.note_byte(rx_byte);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (rx_valid && rx_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout: no beat moved for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        if (stall_left == 0 && out_gaps && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 9);
        if (stall_left != 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // called and returns at a falling edge; valid stays up for the next byte
  task automatic send_byte(input logic [7:0] b);
    if (rx_gaps && $urandom_range(0, 5) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    rx_count++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [15:0] flen);
    send_byte(board.cfg.sync_first);
    send_byte(board.cfg.sync_second);
    send_byte(flen[15:8]);
    send_byte(flen[7:0]);
    if (flen != 0 && flen <= board.cfg.max_payload_length)
      repeat (flen) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    rx_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, value);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_len(input logic [15:0] limit);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return (limit < 16'd48) ? limit : 16'd48;
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin : stimulus
    logic [7:0]  opening[$];
    sld_cfg_t    cfg;
    logic [15:0] flen;
    logic [7:0]  b;
    int unsigned pick;
    int unsigned target;
    bit          hold_done;

    hold_done = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // defaults: log char, CR, LF, byte extremes, one-byte frame, empty frame,
    // max length error, just over the limit, bad second sync
    opening = '{8'h41, CharCr, CharLf, 8'h00, 8'hFF,
                SyncFirstRst, SyncSecondRst, 8'h00, 8'h01, 8'hFF,
                SyncFirstRst, SyncSecondRst, 8'h00, 8'h00,
                SyncFirstRst, SyncSecondRst, 8'hFF, 8'hFF,
                SyncFirstRst, SyncSecondRst, 8'h02, 8'h01,
                SyncFirstRst, SyncFirstRst, 8'h41};
    foreach (opening[i]) send_byte(opening[i]);

    for (int p = 0; p < NumSettings; p++) begin
      drain();
      case (p)
        0:       cfg = '{8'h00, 8'hFF, 16'd0, 16'd0};
        1:       cfg = '{CharLf, CharCr, 16'd16, 16'd3};
        2:       cfg = '{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF};
        3:       cfg = '{CharCr, 8'h00, 16'd6, 16'd1};
        4:       cfg = '{8'hA5, 8'h5A, 16'd40, 16'd8};
        default: cfg = '{SyncFirstRst, SyncSecondRst, MaxPayloadRst, MaxLogRst};
      endcase
      reg_write(RegSyncFirst, {24'h0, cfg.sync_first});
      reg_write(RegSyncSecond, {24'h0, cfg.sync_second});
      reg_write(RegMaxPayload, {16'h0, cfg.max_payload_length});
      reg_write(RegMaxLog, {16'h0, cfg.max_log_chars});

      target = DirectedBytes + (p + 1) * BytesPerSetting;
      while (rx_count < target) begin
        rx_gaps = (p != NumSettings - 1) && ($urandom_range(0, 3) != 0);
        out_gaps = (p != NumSettings - 1) && ($urandom_range(0, 3) != 0);
        if (p == 2 && !hold_done && rx_count + 150 > target) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          send_frame(pick_len(board.cfg.max_payload_length));
        end else if (pick < 13) begin
          flen = board.cfg.max_payload_length;
          if (flen == 16'hFFFF)
            flen = pick_len(16'd48);
          else if ($urandom_range(0, 1) == 0)
            flen = flen + 16'd1;
          else
            flen = 16'($urandom_range(flen + 1, 16'hFFFF));
          send_frame(flen);
        end else if (pick < 15) begin
          b = 8'($urandom_range(0, 255));
          if (b == board.cfg.sync_second) b = b ^ 8'h01;
          send_byte(board.cfg.sync_first);
          send_byte(b);
        end else if (pick < 19) begin
          repeat ($urandom_range(0, 12)) begin
            b = ($urandom_range(0, 7) == 0) ? CharCr : 8'($urandom_range(0, 255));
            if (b == board.cfg.sync_first && $urandom_range(0, 3) != 0) b = b ^ 8'h40;
            send_byte(b);
          end
          case ($urandom_range(0, 3))
            0: begin
              send_byte(CharCr);
              send_byte(CharLf);
            end
            1: ;
            default: send_byte(CharLf);
          endcase
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("sent %0d bytes across %0d register settings incl. a long output hold",
             rx_count, NumSettings + 1);
    $display("beats: %0d payload, %0d log chars, %0d line ends, %0d empty, %0d length errors",
             board.kind_seen[KIND_PAYLOAD], board.kind_seen[KIND_LOG_CHAR],
             board.kind_seen[KIND_LINE_END], board.kind_seen[KIND_EMPTY],
             board.kind_seen[KIND_LEN_ERR]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
